[hw/rtl/cctc_pkg.sv]
// ============================================================================
// cctc_pkg - shared types and constants for the calendar clock tick counter
// Field widths, command codes, reset values and the calendar time record.
// ============================================================================
package cctc_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    // Last year before the count wraps to zero (at most 2**YEAR_W - 1)
    localparam int YEAR_LAST = 9999;

    // Packed width of the time fields on tdata: 40 bits, five whole bytes
    localparam int TDATA_W = SEC_W + MIN_W + HOUR_W + DAY_W + MONTH_W + YEAR_W;

    // Command codes carried on s_tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Calendar limits
    localparam logic [SEC_W:0]   SEC_MAX   = 7'd59;
    localparam logic [MIN_W:0]   MIN_MAX   = 7'd59;
    localparam logic [HOUR_W:0]  HOUR_MAX  = 6'd23;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_29   = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_28   = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_NONE = 5'd0;

    // Reciprocal of 100 scaled by 2**19; exact quotient for years below 2**14
    localparam int RECIP_SHIFT = 19;
    localparam logic [12:0] RECIP_100 = 13'd5243;

    // Time record, last field (second) in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cal_time_t;

    localparam cal_time_t TIME_RESET = '{
        year:   14'd2000,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0
    };

    // One accepted input item
    typedef struct packed {
        logic      cmd;
        cal_time_t load;
    } cctc_item_t;

endpackage

[hw/rtl/cctc_month_len.sv]
// ============================================================================
// cctc_month_len - days in a month
// Gregorian leap test on the year and month length lookup; 0 for bad months.
// ============================================================================
module cctc_month_len
    import cctc_pkg::*;
(
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output logic [DAY_W-1:0]   days
);

    localparam int PROD_W = YEAR_W + 13 + 6;

    logic [PROD_W-1:0] prod;
    logic              div_by_100;
    logic [1:0]        century_lsb;
    logic              leap;

    // year * 5243 / 2**19: quotient by 100 in the upper bits; a multiple of
    // 100 leaves a fraction below 2**11, any other year one above 5000
    assign prod        = PROD_W'(year) * PROD_W'(RECIP_100);
    assign div_by_100  = (prod[RECIP_SHIFT-1:11] == '0);
    assign century_lsb = prod[RECIP_SHIFT+1:RECIP_SHIFT];
    assign leap        = (year[1:0] == 2'd0) && (!div_by_100 || century_lsb == 2'd0);

    always_comb
    begin
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = DAYS_31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = DAYS_30;
            4'd2:                                       days = leap ? DAYS_29 : DAYS_28;
            default:                                    days = DAYS_NONE;
        endcase
    end

endmodule

[hw/rtl/cctc_step.sv]
// ============================================================================
// cctc_step - next calendar state
// Applies one tick or load to the current time and flags a year wrap.
// ============================================================================
module cctc_step
    import cctc_pkg::*;
(
    input  cal_time_t  cur,
    input  cctc_item_t item,
    output cal_time_t  nxt,
    output logic       wrapped
);

    logic [SEC_W:0]     sec_inc;
    logic [MIN_W:0]     min_inc;
    logic [HOUR_W:0]    hour_mid;
    logic [DAY_W:0]     day_inc;
    logic [DAY_W-1:0]   days;
    logic               sec_carry;
    logic               min_carry;
    logic               day_carry;

    cctc_month_len u_month_len (
        .month (cur.month),
        .year  (cur.year),
        .days  (days)
    );

    assign sec_inc   = {1'b0, cur.second} + 1'b1;
    assign min_inc   = {1'b0, cur.minute} + 1'b1;
    assign sec_carry = (sec_inc > SEC_MAX);
    assign min_carry = sec_carry && (min_inc > MIN_MAX);
    assign hour_mid  = {1'b0, cur.hour} + {{HOUR_W{1'b0}}, min_carry};
    // any hour above 23 clears, even one that was loaded that way
    assign day_carry = (hour_mid > HOUR_MAX);
    assign day_inc   = {1'b0, cur.day} + 1'b1;

    always_comb
    begin
        nxt     = cur;
        wrapped = 1'b0;
        unique case (item.cmd)
            CMD_LOAD:
            begin
                nxt = item.load;
            end
            default:
            begin
                nxt.second = sec_carry ? '0 : sec_inc[SEC_W-1:0];
                if (sec_carry)
                begin
                    nxt.minute = min_carry ? '0 : min_inc[MIN_W-1:0];
                end
                nxt.hour = day_carry ? '0 : hour_mid[HOUR_W-1:0];
                if (day_carry)
                begin
                    if (day_inc <= {1'b0, days})
                    begin
                        nxt.day = day_inc[DAY_W-1:0];
                    end
                    else
                    begin
                        nxt.day = DAY_W'(1);
                        if (cur.month < MONTH_DEC)
                        begin
                            nxt.month = cur.month + 1'b1;
                        end
                        else
                        begin
                            nxt.month = MONTH_W'(1);
                            if (cur.year >= YEAR_W'(YEAR_LAST))
                            begin
                                nxt.year = '0;
                                wrapped  = 1'b1;
                            end
                            else
                            begin
                                nxt.year = cur.year + 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
    end

endmodule

[hw/rtl/calendar_clock_tick_counter_unit.sv]
// ============================================================================
// calendar_clock_tick_counter_unit - seconds-to-years calendar clock
// Stream-driven real time clock with Gregorian leap years and a load command.
// ============================================================================
// Each input item is either a one-second tick or a load of a full time and
// date (selected by s_tuser). Every item returns exactly one result: the time
// as it stood before that item, plus a flag on m_tuser that is set when the
// tick carried the year past YEAR_LAST back to zero. The unit sustains one
// item per clock while m_tready stays high: an item waits in the input
// register, then the single-pass step logic (carry chain, month length and
// leap test with one constant multiply) updates the calendar and fills the
// result register. The result register and the input register together
// let a new item enter while an earlier result still waits on
// m_tready. After reset the clock reads
// 2000-01-01 00:00:00.
module calendar_clock_tick_counter_unit
    import cctc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_tvalid,
    output logic               s_tready,
    // s_tdata, low bit up: load_second[5:0], load_minute[11:6],
    // load_hour[16:12], load_day[21:17], load_month[25:22], load_year[39:26]
    input  logic [TDATA_W-1:0] s_tdata,
    // s_tuser: cmd (0 tick, 1 load)
    input  logic               s_tuser,

    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata, low bit up: cur_second[5:0], cur_minute[11:6],
    // cur_hour[16:12], cur_day[21:17], cur_month[25:22], cur_year[39:26]
    output logic [TDATA_W-1:0] m_tdata,
    // m_tuser: year_wrapped
    output logic               m_tuser
);

    logic        in_valid_reg;
    cctc_item_t  in_item_reg;
    cal_time_t   state_reg;
    cal_time_t   state_next;
    logic        out_valid_reg;
    cal_time_t   out_time_reg;
    logic        out_wrap_reg;
    logic        wrap_next;
    logic        advance;

    // Move the held item into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new item whenever the input register empties this cycle
    assign s_tready = !in_valid_reg || advance;

    cctc_step u_step (
        .cur     (state_reg),
        .item    (in_item_reg),
        .nxt     (state_next),
        .wrapped (wrap_next)
    );

    // Input register: hold the item until the step stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd  <= s_tuser;
            in_item_reg.load <= cal_time_t'(s_tdata);
        end
    end

    // Calendar state: advance once per item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TIME_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: report the time before the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_time_reg <= state_reg;
            out_wrap_reg <= wrap_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_time_reg);
    assign m_tuser  = out_wrap_reg;

endmodule
